### hw/rtl/i2r_pkg.sv
`timescale 1ns / 1ps

package i2r_pkg;

  // queue between front and back
  localparam int QPTR_W = 1;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;

  // upper limit of a convertible value
  localparam logic [11:0] VALUE_MAX = 12'd3999;

  // symbol roles inside one decimal digit
  localparam logic [1:0] SYM_ONE  = 2'd0;
  localparam logic [1:0] SYM_FIVE = 2'd1;
  localparam logic [1:0] SYM_TEN  = 2'd2;

  // digit positions
  localparam logic [1:0] POS_ONES  = 2'd0;
  localparam logic [1:0] POS_TENS  = 2'd1;
  localparam logic [1:0] POS_HUND  = 2'd2;
  localparam logic [1:0] POS_THOU  = 2'd3;

  // ascii codes of the numeral characters
  localparam logic [6:0] CH_I = 7'h49;
  localparam logic [6:0] CH_V = 7'h56;
  localparam logic [6:0] CH_X = 7'h58;
  localparam logic [6:0] CH_L = 7'h4C;
  localparam logic [6:0] CH_C = 7'h43;
  localparam logic [6:0] CH_D = 7'h44;
  localparam logic [6:0] CH_M = 7'h4D;
  localparam logic [6:0] CH_NONE = 7'h00;

  // one classified request waiting for the back end
  typedef struct packed {
    logic       oor;
    logic [1:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } entry_t;

  // number of characters a decimal digit turns into
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] len;
    unique case (d)
      4'd1, 4'd2, 4'd3: len = d[2:0];
      4'd4, 4'd9:       len = 3'd2;
      4'd5, 4'd6, 4'd7, 4'd8: len = 3'(d - 4'd4);
      default:          len = 3'd0;
    endcase
    return len;
  endfunction

  // role of the k-th character of a digit
  function automatic logic [1:0] digit_sym(input logic [3:0] d, input logic [1:0] k);
    logic [1:0] sym;
    priority if (d == 4'd9) begin
      sym = (k == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      sym = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5) begin
      sym = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
    end else begin
      sym = SYM_ONE;
    end
    return sym;
  endfunction

  // character for a role at a digit position
  function automatic logic [6:0] letter_of(input logic [1:0] pos, input logic [1:0] sym);
    logic [6:0] ch;
    unique case (pos)
      POS_THOU: ch = CH_M;
      POS_HUND: ch = (sym == SYM_ONE) ? CH_C : ((sym == SYM_FIVE) ? CH_D : CH_M);
      POS_TENS: ch = (sym == SYM_ONE) ? CH_X : ((sym == SYM_FIVE) ? CH_L : CH_C);
      POS_ONES: ch = (sym == SYM_ONE) ? CH_I : ((sym == SYM_FIVE) ? CH_V : CH_X);
      default:  ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/i2r_front.sv
`timescale 1ns / 1ps

module i2r_front
  import i2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] value,
  output logic        push,
  output entry_t      push_data,
  input  logic        full
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HUND = 3'd1;
  localparam logic [2:0] S_HREM = 3'd2;
  localparam logic [2:0] S_TENS = 3'd3;
  localparam logic [2:0] S_ONES = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]  state, state_next;
  logic [9:0]  rem, rem_next;
  logic [1:0]  thou, thou_next;
  logic [3:0]  hund, hund_next;
  logic [3:0]  tens, tens_next;
  logic [3:0]  ones, ones_next;
  logic        oor, oor_next;
  logic [1:0]  thou_c;
  logic [15:0] hprod;
  logic [13:0] tprod;

  // thousands by comparison
  always_comb begin
    priority if (value >= 12'd3000) begin
      thou_c = 2'd3;
    end else if (value >= 12'd2000) begin
      thou_c = 2'd2;
    end else if (value >= 12'd1000) begin
      thou_c = 2'd1;
    end else begin
      thou_c = 2'd0;
    end
  end

  // quotients by reciprocal multiplication, exact over the remainder range
  assign hprod = 16'(rem) * 16'd41;
  assign tprod = 14'(rem[6:0]) * 14'd103;

  // digit extraction sequencer
  always_comb begin
    state_next = state;
    rem_next   = rem;
    thou_next  = thou;
    hund_next  = hund;
    tens_next  = tens;
    ones_next  = ones;
    oor_next   = oor;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          oor_next   = (value == 12'd0) || (value > VALUE_MAX);
          thou_next  = thou_c;
          rem_next   = 10'(value - 12'(thou_c) * 12'd1000);
          state_next = ((value == 12'd0) || (value > VALUE_MAX)) ? S_PUSH : S_HUND;
        end
      end
      S_HUND: begin
        hund_next  = hprod[15:12];
        state_next = S_HREM;
      end
      S_HREM: begin
        rem_next   = 10'(rem - 10'(hund) * 10'd100);
        state_next = S_TENS;
      end
      S_TENS: begin
        tens_next  = tprod[13:10];
        state_next = S_ONES;
      end
      S_ONES: begin
        ones_next  = 4'(rem[6:0] - 7'(tens) * 7'd10);
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (!full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    thou <= thou_next;
    hund <= hund_next;
    tens <= tens_next;
    ones <= ones_next;
    oor  <= oor_next;
  end

  assign in_stall = (state != S_IDLE);
  assign push     = (state == S_PUSH) && !full;

  always_comb begin
    push_data.oor  = oor;
    push_data.thou = thou;
    push_data.hund = hund;
    push_data.tens = tens;
    push_data.ones = ones;
  end

`ifndef ASSERT_OFF
  // reciprocal quotients stay decimal digits
  assert property (@(posedge clk) disable iff (rst)
    (state == S_HREM) |-> (hund <= 4'd9))
    else $error("hundreds digit out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ONES) |-> (tens <= 4'd9))
    else $error("tens digit out of range");
`endif

endmodule

### hw/rtl/i2r_queue.sv
`timescale 1ns / 1ps

module i2r_queue
  import i2r_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   nonempty
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue fill count overflow");
`endif

endmodule

### hw/rtl/i2r_back.sv
`timescale 1ns / 1ps

module i2r_back
  import i2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] letter,
  output logic       last,
  output logic       out_of_range
);

  logic       started;
  logic [1:0] pos;
  logic [1:0] k;
  logic [2:0] len [4];
  logic [3:0] nz;
  logic [3:0] lower;
  logic [1:0] first_pos;
  logic [1:0] next_pos;
  logic [1:0] cur_pos;
  logic [1:0] cur_k;
  logic [3:0] cur_d;
  logic [2:0] cur_len;
  logic       digit_end;
  logic       is_last;
  logic       out_free;
  logic       emit;

  // per-digit character counts
  assign len[POS_THOU] = {1'b0, head.thou};
  assign len[POS_HUND] = digit_len(head.hund);
  assign len[POS_TENS] = digit_len(head.tens);
  assign len[POS_ONES] = digit_len(head.ones);
  assign nz = {len[3] != 3'd0, len[2] != 3'd0, len[1] != 3'd0, len[0] != 3'd0};

  // highest digit that gives characters
  always_comb begin
    priority if (nz[3]) begin
      first_pos = POS_THOU;
    end else if (nz[2]) begin
      first_pos = POS_HUND;
    end else if (nz[1]) begin
      first_pos = POS_TENS;
    end else begin
      first_pos = POS_ONES;
    end
  end

  assign cur_pos = started ? pos : first_pos;
  assign cur_k   = started ? k : 2'd0;

  always_comb begin
    unique case (cur_pos)
      POS_THOU: cur_d = {2'b00, head.thou};
      POS_HUND: cur_d = head.hund;
      POS_TENS: cur_d = head.tens;
      POS_ONES: cur_d = head.ones;
      default:  cur_d = 4'd0;
    endcase
  end

  assign cur_len = len[cur_pos];

  // next non-empty digit below the current one
  assign lower = nz & ~(4'b1111 << cur_pos);
  always_comb begin
    priority if (lower[2]) begin
      next_pos = POS_HUND;
    end else if (lower[1]) begin
      next_pos = POS_TENS;
    end else begin
      next_pos = POS_ONES;
    end
  end

  assign digit_end = ({1'b0, cur_k} + 3'd1) >= cur_len;
  assign is_last   = head.oor || (digit_end && (lower == 4'd0));

  assign out_free = !out_valid || !out_stall;
  assign emit     = head_valid && out_free;
  assign pop      = emit && is_last;

  // walk position within the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pos     <= POS_ONES;
      k       <= 2'd0;
    end else if (emit) begin
      if (is_last) begin
        started <= 1'b0;
      end else begin
        started <= 1'b1;
        if (digit_end) begin
          pos <= next_pos;
          k   <= 2'd0;
        end else begin
          pos <= cur_pos;
          k   <= cur_k + 2'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      letter       <= head.oor ? CH_NONE : letter_of(cur_pos, digit_sym(cur_d, cur_k));
      last         <= is_last;
      out_of_range <= head.oor;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (last && (letter == CH_NONE)))
    else $error("error result not a single empty character");

  assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.oor) |-> (nz != 4'd0))
    else $error("in-range request with no characters");
`endif

endmodule

### hw/rtl/integer_to_roman_numeral.sv
`timescale 1ns / 1ps
// a request passes the digit sequencer (hundreds, remainder, tens, ones),
// the queue and the output register; an out-of-range value skips the digit steps
// the back end sends one character per cycle while out_stall is low, 1 to 15 per
// request; the front end takes no new request until it has pushed the current one
// synchronous reset clears the sequencer, queue pointers and output valid

module integer_to_roman_numeral
  import i2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  letter,
  output logic        last,
  output logic        out_of_range
);

  logic   push;
  entry_t push_data;
  logic   full;
  logic   pop;
  entry_t head;
  logic   nonempty;

  i2r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  i2r_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty)
  );

  i2r_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (nonempty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .letter       (letter),
    .last         (last),
    .out_of_range (out_of_range)
  );

endmodule

### bench/tb_integer_to_roman_numeral.sv
`timescale 1ns / 1ps

module tb_integer_to_roman_numeral
  import i2r_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 46;
  localparam int REPORT_MAX = 10;

  // one expected numeral character, tagged with the request it came from
  typedef struct packed {
    logic [11:0] src;
    logic [6:0]  letter;
    logic        last;
    logic        oor;
  } numeral_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  letter;
  logic        last;
  logic        out_of_range;

  logic [11:0]   pending_values [$];
  numeral_char_t numeral_q [$];
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  integer_to_roman_numeral u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .letter       (letter),
    .last         (last),
    .out_of_range (out_of_range)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append one character to a run being built
  task automatic add_char(inout numeral_char_t run [$], input logic [11:0] v,
                          input logic [6:0] ch);
    numeral_char_t c;
    c.src = v;
    c.letter = ch;
    c.last = 1'b0;
    c.oor = 1'b0;
    run.push_back(c);
  endtask

  // one decimal digit: subtractive pairs for 4 and 9, five-symbol then repeats
  task automatic add_digit(inout numeral_char_t run [$], input logic [11:0] v,
                           input int d, input logic [6:0] one_ch,
                           input logic [6:0] five_ch, input logic [6:0] ten_ch);
    int k;
    if (d == 9) begin
      add_char(run, v, one_ch);
      add_char(run, v, ten_ch);
    end else if (d == 4) begin
      add_char(run, v, one_ch);
      add_char(run, v, five_ch);
    end else begin
      k = d;
      if (k >= 5) begin
        add_char(run, v, five_ch);
        k = k - 5;
      end
      repeat (k) add_char(run, v, one_ch);
    end
  endtask

  // expected characters of one accepted request
  task automatic predict_numeral(input logic [11:0] v);
    numeral_char_t run [$];
    numeral_char_t c;
    int n;
    n = int'(v);
    if (n == 0 || n > int'(VALUE_MAX)) begin
      c.src = v;
      c.letter = CH_NONE;
      c.last = 1'b1;
      c.oor = 1'b1;
      numeral_q.push_back(c);
    end else begin
      repeat (n / 1000) add_char(run, v, CH_M);
      add_digit(run, v, (n / 100) % 10, CH_C, CH_D, CH_M);
      add_digit(run, v, (n / 10) % 10, CH_X, CH_L, CH_C);
      add_digit(run, v, n % 10, CH_I, CH_V, CH_X);
      c = run[run.size() - 1];
      c.last = 1'b1;
      run[run.size() - 1] = c;
      foreach (run[i]) numeral_q.push_back(run[i]);
    end
  endtask

  // request driver: hold a stalled request, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_numeral(value);
      end
      if (pending_values.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        value <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk) begin
    numeral_char_t exp_c;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (numeral_q.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_MAX) begin
            $display("unexpected result: letter=%h last=%b out_of_range=%b",
                     letter, last, out_of_range);
          end
        end else begin
          exp_c = numeral_q.pop_front();
          if (letter !== exp_c.letter || last !== exp_c.last ||
              out_of_range !== exp_c.oor) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < REPORT_MAX) begin
              $display("value %0d: exp letter=%h last=%b oor=%b got letter=%h last=%b oor=%b",
                       exp_c.src, exp_c.letter, exp_c.last, exp_c.oor,
                       letter, last, out_of_range);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_integer_to_roman_numeral failed");
      $finish;
    end
  end

  // stimulus phases and end of run
  initial begin
    logic [11:0] corner_values [$];
    int r;
    int th;
    int hu;
    int te;
    int on;
    corner_values = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10,
                      12'd40, 12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd900,
                      12'd999, 12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd4000,
                      12'd4095, 12'd1365, 12'd2730, 12'd2048};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 75;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 75;
        end
        default: begin
          src_idle_pct = 26;
          snk_stall_pct = 26;
        end
      endcase
      if (phase == 0) begin
        foreach (corner_values[i]) pending_values.push_back(corner_values[i]);
      end
      // mostly valid values, some built digit by digit, a few out of range
      repeat (RANDOM_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 6) begin
          pending_values.push_back(12'($urandom_range(4095, 4000)));
        end else if (r < 9) begin
          pending_values.push_back(12'd0);
        end else if (r < 30) begin
          th = $urandom_range(3, 0);
          hu = $urandom_range(9, 0);
          te = $urandom_range(9, 0);
          on = $urandom_range(9, 0);
          r = th * 1000 + hu * 100 + te * 10 + on;
          pending_values.push_back((r == 0) ? 12'd3888 : 12'(r));
        end else begin
          pending_values.push_back(12'($urandom_range(3999, 1)));
        end
      end
      while (pending_values.size() != 0 || in_valid) @(negedge clk);
    end
    while (numeral_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && numeral_q.size() == 0) begin
      $display("tb_integer_to_roman_numeral passed");
    end else begin
      $display("tb_integer_to_roman_numeral failed");
    end
    $finish;
  end

endmodule
